/* rtl/hkra_pkg.sv */
// Shared constants, types and helper functions for the HSL keyed range adjust block.
package hkra_pkg;

  localparam int FRAC_BITS  = 12;
  localparam int ONE        = 1 << FRAC_BITS;
  localparam int LIGHT_MAX  = 32767;
  localparam int NLANE      = 8;
  localparam int DIV_BITS   = 2;
  localparam int DIV_STAGES = FRAC_BITS / DIV_BITS;
  localparam int NSTAGE     = 1 + DIV_STAGES + 6;
  localparam int EW         = 20;

  typedef logic [2:0] cfg_idx_t;
  localparam cfg_idx_t REG_HUE_WINDOW   = 3'd0;
  localparam cfg_idx_t REG_SAT_WINDOW   = 3'd1;
  localparam cfg_idx_t REG_LIGHT_WINDOW = 3'd2;
  localparam cfg_idx_t REG_HUE_ADJUST   = 3'd3;
  localparam cfg_idx_t REG_SAT_ADJUST   = 3'd4;
  localparam cfg_idx_t REG_LIGHT_ADJUST = 3'd5;
  localparam cfg_idx_t REG_OFFSET_MODE  = 3'd6;
  localparam cfg_idx_t REG_MASK_ONLY    = 3'd7;

  typedef struct packed {
    logic signed [15:0] hue;
    logic signed [15:0] sat;
    logic signed [15:0] light;
  } pix_t;

  typedef struct packed {
    logic [47:0]        hue_win;
    logic [47:0]        sat_win;
    logic [47:0]        light_win;
    logic signed [15:0] hue_adj;
    logic signed [15:0] sat_adj;
    logic signed [15:0] light_adj;
    logic               offset_mode;
    logic               mask_only;
  } cfg_t;

  typedef struct packed {
    logic [16:0]          den;
    logic [16:0]          rem;
    logic [FRAC_BITS-1:0] q;
    logic                 fix;
    logic                 full;
  } lane_t;

  typedef lane_t [NLANE-1:0] lanes_t;

  typedef struct packed {
    logic signed [EW-1:0] e0;
    logic signed [EW-1:0] e1;
    logic signed [EW-1:0] e2;
    logic signed [EW-1:0] e3;
  } edges_t;

  typedef logic [NSTAGE-1:0] stage_vec_t;

  function automatic edges_t win_edges(input logic [47:0] win);
    logic signed [EW-1:0] c2;
    logic signed [EW-1:0] r;
    logic signed [EW-1:0] t2;
    edges_t e;
    c2 = EW'($signed(win[15:0])) <<< 1;
    r  = EW'($signed(win[31:16]));
    t2 = EW'($signed(win[47:32])) <<< 1;
    e.e1 = c2 - r;
    e.e2 = c2 + r;
    e.e0 = e.e1 - t2;
    e.e3 = e.e2 + t2;
    return e;
  endfunction

  function automatic lane_t ss_setup(input logic signed [EW-1:0] e0,
                                     input logic signed [EW-1:0] e1,
                                     input logic signed [EW-1:0] x);
    logic signed [EW-1:0] num;
    logic signed [EW-1:0] den;
    lane_t l;
    num = x - e0;
    den = e1 - e0;
    l = '0;
    if (den < 0) begin
      num = -num;
      den = -den;
    end
    if (den == 0) begin
      l.fix  = 1'b1;
      l.full = !(x < e0);
    end else if (num <= 0) begin
      l.fix = 1'b1;
    end else if (num >= den) begin
      l.fix  = 1'b1;
      l.full = 1'b1;
    end else begin
      l.den = den[16:0];
      l.rem = num[16:0];
    end
    return l;
  endfunction

  function automatic lane_t div_step(input lane_t li);
    logic [17:0] r2;
    lane_t l;
    l = li;
    for (int i = 0; i < DIV_BITS; i++) begin
      r2 = {l.rem, 1'b0};
      if (r2 >= {1'b0, l.den}) begin
        l.rem = 17'(r2 - {1'b0, l.den});
        l.q   = {l.q[FRAC_BITS-2:0], 1'b1};
      end else begin
        l.rem = r2[16:0];
        l.q   = {l.q[FRAC_BITS-2:0], 1'b0};
      end
    end
    return l;
  endfunction

endpackage

/* rtl/hkra_front.sv */
// Input stage: forms the ramp edges and sets up the eight smoothstep divisions.
module hkra_front (
  input  logic           clk,
  input  logic           en,
  input  hkra_pkg::pix_t in_pix,
  input  hkra_pkg::cfg_t cfg,
  output hkra_pkg::lanes_t lanes_r,
  output hkra_pkg::pix_t pix_r
);
  import hkra_pkg::*;

  localparam logic signed [EW-1:0] TWO_ONE = EW'(2 * ONE);

  edges_t he, se, le;
  logic signed [EW-1:0] xh, xh2, xs, xl;
  lanes_t lanes_nxt;

  always_comb begin
    he  = win_edges(cfg.hue_win);
    se  = win_edges(cfg.sat_win);
    le  = win_edges(cfg.light_win);
    xh  = EW'(in_pix.hue) <<< 1;
    xs  = EW'(in_pix.sat) <<< 1;
    xl  = EW'(in_pix.light) <<< 1;
    xh2 = (xh > EW'(ONE)) ? xh - TWO_ONE : xh + TWO_ONE;
    lanes_nxt[0] = ss_setup(he.e0, he.e1, xh);
    lanes_nxt[1] = ss_setup(he.e2, he.e3, xh);
    lanes_nxt[2] = ss_setup(he.e0, he.e1, xh2);
    lanes_nxt[3] = ss_setup(he.e2, he.e3, xh2);
    lanes_nxt[4] = ss_setup(se.e0, se.e1, xs);
    lanes_nxt[5] = ss_setup(se.e2, se.e3, xs);
    lanes_nxt[6] = ss_setup(le.e0, le.e1, xl);
    lanes_nxt[7] = ss_setup(le.e2, le.e3, xl);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lanes_r <= lanes_nxt;
      pix_r   <= in_pix;
    end
  end

endmodule

/* rtl/hkra_div_step.sv */
// One pipelined divider stage: two quotient bits for each of the eight lanes.
module hkra_div_step (
  input  logic             clk,
  input  logic             en,
  input  hkra_pkg::lanes_t lanes,
  input  hkra_pkg::pix_t   pix,
  output hkra_pkg::lanes_t lanes_r,
  output hkra_pkg::pix_t   pix_r
);
  import hkra_pkg::*;

  lanes_t lanes_nxt;

  always_comb begin
    for (int i = 0; i < NLANE; i++) begin
      lanes_nxt[i] = div_step(lanes[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lanes_r <= lanes_nxt;
      pix_r   <= pix;
    end
  end

endmodule

/* rtl/hkra_mask.sv */
// Smoothstep polynomial, channel pulse masks and the minimum mix over three stages.
module hkra_mask (
  input  logic                clk,
  input  logic [2:0]          en,
  input  hkra_pkg::lanes_t    lanes,
  input  hkra_pkg::pix_t      pix,
  output logic signed [13:0]  mix_r,
  output hkra_pkg::pix_t      pix_r
);
  import hkra_pkg::*;

  logic [FRAC_BITS-1:0] u_r   [NLANE];
  logic [FRAC_BITS-1:0] u2_r  [NLANE];
  logic                 fix_r [NLANE];
  logic                 full_r[NLANE];
  logic [FRAC_BITS:0]   ss_r  [NLANE];
  pix_t                 pa_r, pb_r;

  logic [2*FRAC_BITS-1:0] sq_nxt [NLANE];
  logic [FRAC_BITS+1:0]   w_nxt  [NLANE];
  logic [3*FRAC_BITS+1:0] pr_nxt [NLANE];
  logic signed [13:0]     m0, m1, ms, ml, mh, mix_nxt;

  always_comb begin
    for (int i = 0; i < NLANE; i++) begin
      sq_nxt[i] = lanes[i].q * lanes[i].q;
      w_nxt[i]  = (FRAC_BITS+2)'(3 * ONE) - (FRAC_BITS+2)'({u_r[i], 1'b0});
      pr_nxt[i] = u2_r[i] * w_nxt[i];
    end
    m0 = $signed({1'b0, ss_r[0]}) - $signed({1'b0, ss_r[1]});
    m1 = $signed({1'b0, ss_r[2]}) - $signed({1'b0, ss_r[3]});
    ms = $signed({1'b0, ss_r[4]}) - $signed({1'b0, ss_r[5]});
    ml = $signed({1'b0, ss_r[6]}) - $signed({1'b0, ss_r[7]});
    mh = (m1 > m0) ? m1 : m0;
    mix_nxt = mh;
    if (ms < mix_nxt) begin
      mix_nxt = ms;
    end
    if (ml < mix_nxt) begin
      mix_nxt = ml;
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      for (int i = 0; i < NLANE; i++) begin
        u_r[i]    <= lanes[i].q;
        u2_r[i]   <= FRAC_BITS'(sq_nxt[i] >> FRAC_BITS);
        fix_r[i]  <= lanes[i].fix;
        full_r[i] <= lanes[i].full;
      end
      pa_r <= pix;
    end
    if (en[1]) begin
      for (int i = 0; i < NLANE; i++) begin
        if (fix_r[i]) begin
          ss_r[i] <= full_r[i] ? (FRAC_BITS+1)'(ONE) : '0;
        end else begin
          ss_r[i] <= (FRAC_BITS+1)'(pr_nxt[i] >> FRAC_BITS);
        end
      end
      pb_r <= pa_r;
    end
    if (en[2]) begin
      mix_r <= mix_nxt;
      pix_r <= pb_r;
    end
  end

endmodule

/* rtl/hkra_adjust.sv */
// Applies the mix to hue, sat and light, then wraps and clamps; mask-only outputs the mix as light.
module hkra_adjust (
  input  logic               clk,
  input  logic [2:0]         en,
  input  logic signed [13:0] mix,
  input  hkra_pkg::pix_t     pix,
  input  hkra_pkg::cfg_t     cfg,
  output logic signed [12:0] hue_r,
  output logic [12:0]        sat_r,
  output logic [14:0]        light_r
);
  import hkra_pkg::*;

  logic signed [29:0] hp, sop, lop;
  logic signed [31:0] spp, lpp;
  logic signed [17:0] hadd_r, soff_r, loff_r;
  logic signed [19:0] ps_r, pl_r;
  logic signed [13:0] mix_a_r, mix_b_r;
  pix_t               pa_r, pb_r;

  logic signed [20:0] ds, dl;
  logic signed [34:0] smp, lmp;
  logic signed [18:0] h1_r;
  logic signed [22:0] st_r, lt_r;
  logic signed [22:0] st_nxt, lt_nxt;

  logic signed [23:0] s2, l2;
  logic signed [18:0] hneg;
  logic signed [12:0] hmod;

  always_comb begin
    hp  = mix * cfg.hue_adj;
    sop = mix * cfg.sat_adj;
    lop = mix * cfg.light_adj;
    spp = pix.sat * cfg.sat_adj;
    lpp = pix.light * cfg.light_adj;

    ds  = 21'(ps_r) - 21'(pa_r.sat);
    dl  = 21'(pl_r) - 21'(pa_r.light);
    smp = mix_a_r * ds;
    lmp = mix_a_r * dl;
    if (cfg.offset_mode) begin
      st_nxt = 23'(soff_r);
      lt_nxt = 23'(loff_r);
    end else begin
      st_nxt = 23'(smp >>> FRAC_BITS);
      lt_nxt = 23'(lmp >>> FRAC_BITS);
    end

    s2   = 24'(pb_r.sat) + 24'(st_r);
    l2   = 24'(pb_r.light) + 24'(lt_r);
    hneg = -h1_r;
    if (h1_r < 0) begin
      hmod = -$signed({1'b0, hneg[FRAC_BITS-1:0]});
    end else begin
      hmod = $signed({1'b0, h1_r[FRAC_BITS-1:0]});
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      hadd_r  <= 18'(hp >>> FRAC_BITS);
      soff_r  <= 18'(sop >>> FRAC_BITS);
      loff_r  <= 18'(lop >>> FRAC_BITS);
      ps_r    <= 20'(spp >>> FRAC_BITS);
      pl_r    <= 20'(lpp >>> FRAC_BITS);
      mix_a_r <= mix;
      pa_r    <= pix;
    end
    if (en[1]) begin
      h1_r    <= 19'(pa_r.hue) + 19'(hadd_r);
      st_r    <= st_nxt;
      lt_r    <= lt_nxt;
      mix_b_r <= mix_a_r;
      pb_r    <= pa_r;
    end
    if (en[2]) begin
      if (cfg.mask_only) begin
        hue_r   <= '0;
        sat_r   <= '0;
        light_r <= (mix_b_r < 0) ? '0 : 15'(mix_b_r);
      end else begin
        hue_r <= hmod;
        if (s2 < 0) begin
          sat_r <= '0;
        end else if (s2 > 24'(ONE)) begin
          sat_r <= 13'(ONE);
        end else begin
          sat_r <= s2[12:0];
        end
        if (l2 < 0) begin
          light_r <= '0;
        end else if (l2 > 24'(LIGHT_MAX)) begin
          light_r <= 15'(LIGHT_MAX);
        end else begin
          light_r <= l2[14:0];
        end
      end
    end
  end

endmodule

/* rtl/hsl_keyed_range_adjust.sv */
// Top level of the HSL keyed range adjust block: registers, stage control, datapath.
//
//   channel | direction | handshake          | payload
//   in      | input     | in_valid/in_ready  | in_hue_in, in_sat_in, in_light_in
//   out     | output    | out_valid/out_ready| out_hue_out, out_sat_out, out_light_out
//   cfg     | input     | cfg_we             | cfg_index, cfg_wdata
//
// One item per cycle unless the output stalls; items pass front, divider, mask and adjust stages.
// The depth is set by the six-stage radix-4 divider that forms the smoothstep ramps.
// Reset clears the configuration registers and all stage valid bits.
// Each stage advances when it is empty or the stage after it advances, so bubbles close
// up and a stall at the output holds each occupied stage that has no empty stage after it.
module hsl_keyed_range_adjust (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic signed [15:0]   in_hue_in,
  input  logic signed [15:0]   in_sat_in,
  input  logic signed [15:0]   in_light_in,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic signed [12:0]   out_hue_out,
  output logic [12:0]          out_sat_out,
  output logic [14:0]          out_light_out,
  input  logic                 cfg_we,
  input  hkra_pkg::cfg_idx_t   cfg_index,
  input  logic [47:0]          cfg_wdata
);
  import hkra_pkg::*;

  cfg_t       cfg_r;
  stage_vec_t vld_r, vld_nxt, adv;
  pix_t       in_pix;
  lanes_t     div_l [DIV_STAGES+1];
  pix_t       div_p [DIV_STAGES+1];
  logic signed [13:0] mix;
  pix_t       mix_p;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_HUE_WINDOW:   cfg_r.hue_win     <= cfg_wdata;
        REG_SAT_WINDOW:   cfg_r.sat_win     <= cfg_wdata;
        REG_LIGHT_WINDOW: cfg_r.light_win   <= cfg_wdata;
        REG_HUE_ADJUST:   cfg_r.hue_adj     <= cfg_wdata[15:0];
        REG_SAT_ADJUST:   cfg_r.sat_adj     <= cfg_wdata[15:0];
        REG_LIGHT_ADJUST: cfg_r.light_adj   <= cfg_wdata[15:0];
        REG_OFFSET_MODE:  cfg_r.offset_mode <= cfg_wdata[0];
        REG_MASK_ONLY:    cfg_r.mask_only   <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    adv[NSTAGE-1] = !vld_r[NSTAGE-1] || out_ready;
    for (int k = NSTAGE - 2; k >= 0; k--) begin
      adv[k] = !vld_r[k] || adv[k+1];
    end
    for (int k = 0; k < NSTAGE; k++) begin
      if (adv[k]) begin
        vld_nxt[k] = (k == 0) ? in_valid : vld_r[(k == 0) ? 0 : k - 1];
      end else begin
        vld_nxt[k] = vld_r[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign in_ready  = adv[0];
  assign out_valid = vld_r[NSTAGE-1];

  assign in_pix.hue   = in_hue_in;
  assign in_pix.sat   = in_sat_in;
  assign in_pix.light = in_light_in;

  hkra_front u_front (
    .clk     (clk),
    .en      (adv[0]),
    .in_pix  (in_pix),
    .cfg     (cfg_r),
    .lanes_r (div_l[0]),
    .pix_r   (div_p[0])
  );

  for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
    hkra_div_step u_div (
      .clk     (clk),
      .en      (adv[1+g]),
      .lanes   (div_l[g]),
      .pix     (div_p[g]),
      .lanes_r (div_l[g+1]),
      .pix_r   (div_p[g+1])
    );
  end

  hkra_mask u_mask (
    .clk   (clk),
    .en    (adv[DIV_STAGES+1 +: 3]),
    .lanes (div_l[DIV_STAGES]),
    .pix   (div_p[DIV_STAGES]),
    .mix_r (mix),
    .pix_r (mix_p)
  );

  hkra_adjust u_adjust (
    .clk     (clk),
    .en      (adv[DIV_STAGES+4 +: 3]),
    .mix     (mix),
    .pix     (mix_p),
    .cfg     (cfg_r),
    .hue_r   (out_hue_out),
    .sat_r   (out_sat_out),
    .light_r (out_light_out)
  );

  a_enter: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> vld_r[0])
    else $error("accepted item did not enter the first stage");

  a_mask_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && cfg_r.mask_only |-> out_hue_out == 0 && out_sat_out == 0)
    else $error("mask mode item has nonzero hue or saturation");

  a_sat_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_sat_out <= 13'(ONE))
    else $error("saturation above one");

  a_hue_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_hue_out >= -13'sd4095 && out_hue_out <= 13'sd4095)
    else $error("hue outside one turn");

endmodule

/* sim/tb_top.sv */
// Self-checking testbench for the HSL keyed range adjust block with its own pixel predictor.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import hkra_pkg::*;

  typedef struct {
    logic signed [12:0] hue;
    logic [12:0]        sat;
    logic [14:0]        light;
  } hsl_res_t;

  class pixel_board;
    logic [47:0] win [3];
    logic signed [15:0] adj [3];
    bit offset_mode, mask_only;
    hsl_res_t pending [$];
    int errors, checked;

    function new();
      for (int i = 0; i < 3; i++) begin
        win[i] = '0;
        adj[i] = '0;
      end
      offset_mode = 0;
      mask_only = 0;
      errors = 0;
      checked = 0;
    endfunction

    function void set_reg(cfg_idx_t idx, logic [47:0] d);
      case (idx)
        REG_HUE_WINDOW: win[0] = d;
        REG_SAT_WINDOW: win[1] = d;
        REG_LIGHT_WINDOW: win[2] = d;
        REG_HUE_ADJUST: adj[0] = d[15:0];
        REG_SAT_ADJUST: adj[1] = d[15:0];
        REG_LIGHT_ADJUST: adj[2] = d[15:0];
        REG_OFFSET_MODE: offset_mode = d[0];
        default: mask_only = d[0];
      endcase
    endfunction

    function longint fdiv_one(longint v);
      if (v >= 0) return v >>> FRAC_BITS;
      return -(((-v) + (ONE - 1)) >>> FRAC_BITS);
    endfunction

    function longint ramp(longint e0, longint e1, longint x);
      longint num, den, u, u2;
      if (e0 == e1) return (x < e0) ? 0 : ONE;
      num = x - e0;
      den = e1 - e0;
      if (den < 0) begin
        num = -num;
        den = -den;
      end
      if (num <= 0) return 0;
      if (num >= den) return ONE;
      u = (num * ONE) / den;
      u2 = (u * u) >>> FRAC_BITS;
      return (u2 * (3 * ONE - 2 * u)) >>> FRAC_BITS;
    endfunction

    function longint window_mask(logic [47:0] w, longint x2);
      longint c, r, t, e0, e1, e2, e3;
      c = longint'($signed(w[15:0]));
      r = longint'($signed(w[31:16]));
      t = longint'($signed(w[47:32]));
      e1 = 2 * c - r;
      e2 = 2 * c + r;
      e0 = e1 - 2 * t;
      e3 = e2 + 2 * t;
      return ramp(e0, e1, x2) - ramp(e2, e3, x2);
    endfunction

    function longint blend(longint v, longint a, longint m);
      longint p;
      if (offset_mode) return v + fdiv_one(m * a);
      p = fdiv_one(v * a);
      return v + fdiv_one(m * (p - v));
    endfunction

    function void note_pixel(logic signed [15:0] hi, logic signed [15:0] si,
                             logic signed [15:0] li);
      longint h, s, l, mh, mh2, ms, ml, m;
      hsl_res_t r;
      h = hi;
      s = si;
      l = li;
      mh = window_mask(win[0], 2 * h);
      mh2 = window_mask(win[0], 2 * h + ((2 * h > ONE) ? -2 * ONE : 2 * ONE));
      if (mh2 > mh) mh = mh2;
      ms = window_mask(win[1], 2 * s);
      ml = window_mask(win[2], 2 * l);
      m = mh;
      if (ms < m) m = ms;
      if (ml < m) m = ml;
      if (mask_only) begin
        h = 0;
        s = 0;
        l = m;
      end else begin
        h = h + fdiv_one(m * adj[0]);
        s = blend(s, adj[1], m);
        l = blend(l, adj[2], m);
      end
      h = h % ONE;
      if (s < 0) s = 0;
      if (s > ONE) s = ONE;
      if (l < 0) l = 0;
      if (l > LIGHT_MAX) l = LIGHT_MAX;
      r.hue = h[12:0];
      r.sat = s[12:0];
      r.light = l[14:0];
      pending.push_back(r);
    endfunction

    task report(string what, longint got, longint want);
      $display("mismatch %s: got %0d expected %0d", what, got, want);
      errors++;
    endtask

    task check_pixel(logic signed [12:0] h, logic [12:0] s, logic [14:0] l);
      hsl_res_t e;
      if (pending.size() == 0) begin
        report("unexpected result", 0, 0);
        return;
      end
      e = pending.pop_front();
      checked++;
      if (h !== e.hue) report("hue", h, e.hue);
      if (s !== e.sat) report("sat", s, e.sat);
      if (l !== e.light) report("light", l, e.light);
    endtask
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0, in_ready, out_valid, out_ready = 0;
  logic signed [15:0] in_hue_in = 0, in_sat_in = 0, in_light_in = 0;
  logic signed [12:0] out_hue_out;
  logic [12:0] out_sat_out;
  logic [14:0] out_light_out;
  logic cfg_we = 0;
  cfg_idx_t cfg_index = REG_HUE_WINDOW;
  logic [47:0] cfg_wdata = '0;

  pixel_board board = new();
  int send_idle = 0, recv_stall = 0, quiet = 0, sent = 0;
  localparam int QUIET_LIMIT = 5000;

  always #6 clk = ~clk;

  hsl_keyed_range_adjust dut (.*);

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) board.note_pixel(in_hue_in, in_sat_in, in_light_in);
      if (out_valid && out_ready) board.check_pixel(out_hue_out, out_sat_out, out_light_out);
      quiet <= ((in_valid && in_ready) || (out_valid && out_ready)) ? 0 : quiet + 1;
      out_ready <= ($urandom_range(99) >= recv_stall);
    end
  end

  always @(posedge clk) begin
    if (quiet >= QUIET_LIMIT) begin
      $display("watchdog expired");
      $display("FAILURE");
      $finish;
    end
  end

  task write_reg(cfg_idx_t idx, logic [47:0] d);
    in_valid <= 0;
    while (sent != board.checked) @(posedge clk);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_wdata <= d;
    board.set_reg(idx, d);
    @(posedge clk);
    cfg_we <= 0;
    @(posedge clk);
  endtask

  task drain();
    in_valid <= 0;
    while (sent != board.checked) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task send_pixel(logic signed [15:0] h, logic signed [15:0] s, logic signed [15:0] l);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    in_hue_in <= h;
    in_sat_in <= s;
    in_light_in <= l;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent++;
  endtask

  function logic [47:0] make_window();
    logic [15:0] c, r, t;
    case ($urandom_range(3))
      0: begin
        c = 16'($urandom);
        r = 16'($urandom);
        t = 16'($urandom);
      end
      1: begin
        c = 16'($urandom_range(4096));
        r = 16'($urandom_range(4096));
        t = 0;
      end
      default: begin
        c = 16'($urandom_range(4096));
        r = 16'($urandom_range(3000));
        t = 16'($urandom_range(1500));
      end
    endcase
    return {t, r, c};
  endfunction

  function logic signed [15:0] pick_value();
    case ($urandom_range(3))
      0: return 16'($urandom);
      1: return 16'($urandom_range(6000)) - 16'sd1000;
      default: return 16'($urandom_range(4096));
    endcase
  endfunction

  task random_setup(int phase);
    for (int i = 0; i < 3; i++) write_reg(cfg_idx_t'(i), make_window());
    for (int i = 3; i < 6; i++) write_reg(cfg_idx_t'(i),
        ($urandom_range(3) == 0) ? 48'($urandom) : 48'($urandom_range(8192)));
    write_reg(REG_OFFSET_MODE, 48'($urandom_range(1)));
    write_reg(REG_MASK_ONLY, 48'(($urandom_range(4) == 0) ? 1 : 0));
    case (phase % 4)
      0: begin send_idle = 0; recv_stall = 0; end
      1: begin send_idle = 79; recv_stall = 0; end
      2: begin send_idle = 0; recv_stall = 79; end
      default: begin send_idle = 34; recv_stall = 34; end
    endcase
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    send_pixel(16'sh7fff, 16'sh7fff, 16'sh7fff);
    send_pixel(-16'sh8000, -16'sh8000, -16'sh8000);
    write_reg(REG_HUE_WINDOW, {16'd512, 16'd1024, 16'd0});
    write_reg(REG_SAT_WINDOW, {16'd0, 16'd4096, 16'd2048});
    write_reg(REG_LIGHT_WINDOW, {16'hffff, 16'h8000, 16'h7fff});
    write_reg(REG_HUE_ADJUST, 48'h7fff);
    write_reg(REG_SAT_ADJUST, 48'h8000);
    write_reg(REG_LIGHT_ADJUST, 48'h7fff);
    write_reg(REG_OFFSET_MODE, 48'd1);
    write_reg(REG_MASK_ONLY, 48'd0);
    send_pixel(16'sd0, 16'sd2048, 16'sd2048);
    send_pixel(16'sd4000, 16'sd1024, 16'sd30000);
    send_pixel(16'sd2049, 16'sd4096, -16'sd1);
    send_pixel(-16'sd100, 16'sd0, 16'sh7fff);
    send_pixel(16'sd1536, 16'sd2048, 16'sd0);
    write_reg(REG_OFFSET_MODE, 48'd0);
    send_pixel(16'sd100, 16'sd3000, 16'sd20000);
    send_pixel(16'sh7fff, -16'sh8000, 16'sd100);
    drain();
    write_reg(REG_MASK_ONLY, 48'd1);
    write_reg(REG_SAT_WINDOW, {16'd0, 16'hf000, 16'd2048});
    send_pixel(16'sd0, 16'sd2048, 16'sd2048);
    send_pixel(16'sd3000, 16'sd2500, -16'sd5);
    send_pixel(-16'sd4000, 16'sd1200, 16'sd500);
    drain();
    for (int p = 0; p < 25; p++) begin
      random_setup(p);
      for (int k = 0; k < 50; k++)
        send_pixel(pick_value(), pick_value(), pick_value());
      drain();
    end
    $display("Sent %0d pixels over 25 random register settings and 4 flow-control mixes;",
             sent);
    $display("checked %0d results.", board.checked);
    if (board.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
